// ----- rtl/core/interrupt_priority_dispatch_assert.svh -----
// Assertion macros for the interrupt dispatch block.
// Define NO_ASSERTIONS to compile them away.
`ifndef INTERRUPT_PRIORITY_DISPATCH_ASSERT_SVH
`define INTERRUPT_PRIORITY_DISPATCH_ASSERT_SVH

`ifndef NO_ASSERTIONS

`define IPD_ASSERT_HOLDS(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("ipd assertion failed");

`define IPD_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("ipd assertion failed");

`else

`define IPD_ASSERT_HOLDS(lbl, clk, rstn, prop)

`define IPD_ASSERT_NEXT(lbl, clk, rstn, ante, cons)

`endif

`endif

// ----- rtl/core/ipd_pkg.sv -----
`default_nettype none

package ipd_pkg;

    localparam int NUM_SOURCES = 5;
    localparam int SRC_W       = 3;
    localparam int JOB_DEPTH   = 4;
    localparam int PTR_W       = $clog2(JOB_DEPTH);
    localparam int CNT_W       = $clog2(JOB_DEPTH + 1);

    localparam logic [15:0] VECTOR_BASE  = 16'h0040;
    localparam logic [15:0] PC_HIGH_MASK = 16'hFF00;

    typedef enum logic [1:0] {
        KIND_REQUEST = 2'd0,
        KIND_ENABLE  = 2'd1,
        KIND_MASTER  = 2'd2,
        KIND_SERVICE = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        PH_HIGH  = 2'd0,
        PH_LOW   = 2'd1,
        PH_FINAL = 2'd2
    } phase_t;

    typedef struct packed {
        kind_t        kind;
        logic [2:0]   source;
        logic [4:0]   value;
        logic [15:0]  pc;
        logic [15:0]  sp;
    } in_item_t;

    typedef struct packed {
        logic         write_valid;
        logic [15:0]  write_addr;
        logic [7:0]   write_data;
        logic         taken;
        logic [15:0]  new_pc;
        logic [15:0]  new_sp;
        logic [4:0]   pending_flags;
        logic         last;
    } out_item_t;

    // Work handed from the front part to the back part.
    typedef struct packed {
        logic                   dispatch;
        logic [SRC_W-1:0]       src;
        logic [15:0]            pc;
        logic [15:0]            sp;
        logic [NUM_SOURCES-1:0] flags;
    } job_t;

    typedef struct packed {
        logic             full;
        logic             empty;
        logic [CNT_W-1:0] count;
    } queue_status_t;

    function automatic logic [15:0] vector_of(input logic [SRC_W-1:0] src);
        vector_of = VECTOR_BASE + {10'd0, src, 3'b000};
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/interrupt_priority_dispatch.sv -----
// Channel  | Handshake           | Payload            | Transaction when
// ---------+---------------------+--------------------+-------------------------
// input    | push / full         | item   (in_item_t) | push high, full low
// result   | empty / pop         | result (out_item_t)| pop high, empty low
//
// An item is taken every cycle while the four-entry job queue has room.
// The back part emits one result per cycle from its output register while pop
// is high, so a dispatching service check yields three results and any other item one.
// The first result of an item is registered in the job queue, then in the output register.
// Reset clears the request flags, enables, master enable, queue and output.
// A stalled result port fills the queue, which then raises full.
`default_nettype none

`include "interrupt_priority_dispatch_assert.svh"

module interrupt_priority_dispatch
    import ipd_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     push,
    output logic          full,
    input  wire in_item_t item,
    output logic          empty,
    input  wire logic     pop,
    output out_item_t     result
);

    job_t          front_job;
    job_t          head_job;
    queue_status_t q_status;
    logic          accept;
    logic          job_done;

    assign accept = push && !q_status.full;
    assign full   = q_status.full;

    ipd_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .item   (item),
        .job    (front_job)
    );

    ipd_job_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr_en  (accept),
        .wr_job (front_job),
        .rd_en  (job_done),
        .rd_job (head_job),
        .status (q_status)
    );

    ipd_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .job      (head_job),
        .q_status (q_status),
        .job_done (job_done),
        .pop      (pop),
        .empty    (empty),
        .result   (result)
    );

    `IPD_ASSERT_HOLDS(a_count_bound, clk, rst_n, q_status.count <= CNT_W'(JOB_DEPTH))
    `IPD_ASSERT_HOLDS(a_write_not_last, clk, rst_n, (!empty && result.write_valid) |-> !result.last)
    `IPD_ASSERT_NEXT(a_write_followed, clk, rst_n, pop && !empty && result.write_valid, !empty)

endmodule

`default_nettype wire

// ----- rtl/core/ipd_front.sv -----
`default_nettype none

module ipd_front
    import ipd_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     accept,
    input  wire in_item_t item,
    output job_t          job
);

    logic [NUM_SOURCES-1:0] flags_reg, flags_next;
    logic [NUM_SOURCES-1:0] enable_reg, enable_next;
    logic                   master_reg, master_next;
    logic [NUM_SOURCES-1:0] ready;
    logic [SRC_W-1:0]       winner;
    logic                   dispatch;

    always_comb
    begin
        ready  = flags_reg & enable_reg;
        winner = '0;
        // Scan from the top so that the lowest enabled pending source wins.
        for (int i = NUM_SOURCES - 1; i >= 0; i--)
        begin
            if (ready[i])
            begin
                winner = SRC_W'(i);
            end
        end
        dispatch = (item.kind == KIND_SERVICE) && master_reg && (ready != '0);
    end

    always_comb
    begin
        flags_next  = flags_reg;
        enable_next = enable_reg;
        master_next = master_reg;
        case (item.kind)
            KIND_REQUEST:
            begin
                if (item.source < SRC_W'(NUM_SOURCES))
                begin
                    flags_next = flags_reg | (NUM_SOURCES'(1) << item.source);
                end
            end
            KIND_ENABLE:
            begin
                enable_next = item.value[NUM_SOURCES-1:0];
            end
            KIND_MASTER:
            begin
                master_next = item.value[0];
            end
            KIND_SERVICE:
            begin
                if (dispatch)
                begin
                    master_next = 1'b0;
                    flags_next  = flags_reg & ~(NUM_SOURCES'(1) << winner);
                end
            end
            default:
            begin
                flags_next = flags_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flags_reg  <= '0;
            enable_reg <= '0;
            master_reg <= 1'b0;
        end
        else if (accept)
        begin
            flags_reg  <= flags_next;
            enable_reg <= enable_next;
            master_reg <= master_next;
        end
    end

    assign job.dispatch = dispatch;
    assign job.src      = winner;
    assign job.pc       = item.pc;
    assign job.sp       = item.sp;
    assign job.flags    = flags_next;

endmodule

`default_nettype wire

// ----- rtl/core/ipd_job_queue.sv -----
`default_nettype none

module ipd_job_queue
    import ipd_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    wr_en,
    input  wire job_t    wr_job,
    input  wire logic    rd_en,
    output job_t         rd_job,
    output queue_status_t status
);

    job_t             slots [JOB_DEPTH];
    job_t             head_reg;
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_wr, do_rd;

    assign status.full  = (count_reg == CNT_W'(JOB_DEPTH));
    assign status.empty = (count_reg == '0);
    assign status.count = count_reg;

    assign do_wr = wr_en && !status.full;
    assign do_rd = rd_en && !status.empty;

    always_comb
    begin
        wr_ptr_next = do_wr ? wr_ptr_reg + PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_rd ? rd_ptr_reg + PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // The head entry is registered from the slot at the next read pointer; a job
    // written to that slot in the same cycle is forwarded straight through.
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            slots[wr_ptr_reg] <= wr_job;
        end
        if (do_wr && (wr_ptr_reg == rd_ptr_next))
        begin
            head_reg <= wr_job;
        end
        else
        begin
            head_reg <= slots[rd_ptr_next];
        end
    end

    assign rd_job = head_reg;

endmodule

`default_nettype wire

// ----- rtl/core/ipd_back.sv -----
`default_nettype none

module ipd_back
    import ipd_pkg::*;
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire job_t          job,
    input  wire queue_status_t q_status,
    output logic               job_done,
    input  wire logic          pop,
    output logic               empty,
    output out_item_t          result
);

    phase_t    phase_reg, phase_next;
    out_item_t out_reg, out_next;
    logic      out_valid_reg;
    logic      load;
    logic      is_last;
    logic [15:0] sp_m1, sp_m2;

    // The output register refills in the same cycle that its transaction is taken, if a job is waiting.
    assign load = !q_status.empty && (!out_valid_reg || pop);

    always_comb
    begin
        sp_m1    = job.sp - 16'd1;
        sp_m2    = job.sp - 16'd2;
        out_next = '0;
        out_next.pending_flags = job.flags;
        is_last    = 1'b1;
        phase_next = phase_reg;
        if (!job.dispatch)
        begin
            out_next.new_pc = job.pc;
            out_next.new_sp = job.sp;
            out_next.last   = 1'b1;
        end
        else
        begin
            case (phase_reg)
                PH_HIGH:
                begin
                    out_next.write_valid = 1'b1;
                    out_next.write_addr  = sp_m1;
                    out_next.write_data  = 8'((job.pc & PC_HIGH_MASK) >> 8);
                    is_last = 1'b0;
                end
                PH_LOW:
                begin
                    out_next.write_valid = 1'b1;
                    out_next.write_addr  = sp_m2;
                    out_next.write_data  = job.pc[7:0];
                    is_last = 1'b0;
                end
                PH_FINAL:
                begin
                    out_next.taken  = 1'b1;
                    out_next.new_pc = vector_of(job.src);
                    out_next.new_sp = sp_m2;
                    out_next.last   = 1'b1;
                end
                default:
                begin
                    out_next.last = 1'b1;
                end
            endcase
        end
        if (load)
        begin
            case (phase_reg)
                PH_HIGH:  phase_next = is_last ? PH_HIGH : PH_LOW;
                PH_LOW:   phase_next = PH_FINAL;
                PH_FINAL: phase_next = PH_HIGH;
                default:  phase_next = PH_HIGH;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HIGH;
        end
        else
        begin
            phase_reg <= phase_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (pop)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_reg <= out_next;
        end
    end

    assign job_done = load && is_last;
    assign empty    = !out_valid_reg;
    assign result   = out_reg;

endmodule

`default_nettype wire

// ----- dv/tb_interrupt_priority_dispatch.sv -----
`timescale 1ns / 100ps

module tb_interrupt_priority_dispatch;
    import ipd_pkg::*;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      push = 1'b0;
    logic      full;
    in_item_t  item = '0;
    logic      empty;
    logic      pop = 1'b0;
    out_item_t result;

    // Predicted controller state.
    logic [NUM_SOURCES-1:0] irq_flags = '0;
    logic [NUM_SOURCES-1:0] irq_enable = '0;
    logic                   irq_master = 1'b0;

    out_item_t expected_results[$];

    int  items_sent = 0;
    int  results_seen = 0;
    int  dispatch_count = 0;
    int  fail_count = 0;
    int  pop_hold = 0;
    bit  src_idle_en = 1'b1;
    bit  sink_idle_en = 1'b1;

    interrupt_priority_dispatch u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .full   (full),
        .item   (item),
        .empty  (empty),
        .pop    (pop),
        .result (result)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    initial
    begin
        #5_000_000;
        $display("Regression FAIL");
        $finish;
    end

    // Mostly short gaps, now and then a long one.
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 19);
        if (r < 14)
            return $urandom_range(0, 2);
        else if (r < 18)
            return $urandom_range(3, 8);
        return $urandom_range(15, 40);
    endfunction

    // Works out the results of one accepted transaction and updates the state.
    function automatic void predict_dispatch(in_item_t it);
        logic [NUM_SOURCES-1:0] ready;
        int        src;
        out_item_t r;
        r = '0;
        case (it.kind)
            KIND_REQUEST:
            begin
                if (it.source < NUM_SOURCES)
                    irq_flags[it.source] = 1'b1;
            end
            KIND_ENABLE:
                irq_enable = it.value;
            KIND_MASTER:
                irq_master = it.value[0];
            default:
            begin
                ready = irq_flags & irq_enable;
                if (irq_master && ready != '0)
                begin
                    src = 0;
                    while (!ready[src])
                        src++;
                    irq_master = 1'b0;
                    irq_flags[src] = 1'b0;
                    r.write_valid = 1'b1;
                    r.pending_flags = irq_flags;
                    r.write_addr = it.sp - 16'd1;
                    r.write_data = it.pc[15:8];
                    expected_results.push_back(r);
                    r.write_addr = it.sp - 16'd2;
                    r.write_data = it.pc[7:0];
                    expected_results.push_back(r);
                    r = '0;
                    r.taken = 1'b1;
                    r.new_pc = VECTOR_BASE + 16'(src * 8);
                    r.new_sp = it.sp - 16'd2;
                    r.pending_flags = irq_flags;
                    r.last = 1'b1;
                    expected_results.push_back(r);
                    dispatch_count++;
                    return;
                end
            end
        endcase
        r.new_pc = it.pc;
        r.new_sp = it.sp;
        r.pending_flags = irq_flags;
        r.last = 1'b1;
        expected_results.push_back(r);
    endfunction

    function automatic bit result_differs(out_item_t want, out_item_t got);
        return (got.write_valid !== want.write_valid) ||
               (got.write_addr !== want.write_addr) ||
               (got.write_data !== want.write_data) ||
               (got.taken !== want.taken) ||
               (got.new_pc !== want.new_pc) ||
               (got.new_sp !== want.new_sp) ||
               (got.pending_flags !== want.pending_flags) ||
               (got.last !== want.last);
    endfunction

    task automatic note_failure(string what, out_item_t want, out_item_t got);
        fail_count++;
        if (fail_count <= 10)
        begin
            $display("%0t: %s", $realtime, what);
            $display("  expected wv=%b addr=%h data=%h taken=%b pc=%h sp=%h flags=%b last=%b",
                     want.write_valid, want.write_addr, want.write_data, want.taken,
                     want.new_pc, want.new_sp, want.pending_flags, want.last);
            $display("  actual   wv=%b addr=%h data=%h taken=%b pc=%h sp=%h flags=%b last=%b",
                     got.write_valid, got.write_addr, got.write_data, got.taken,
                     got.new_pc, got.new_sp, got.pending_flags, got.last);
        end
    endtask

    always @(posedge clk)
    begin : check_results
        out_item_t want;
        if (rst_n && pop && !empty)
        begin
            results_seen++;
            if (expected_results.size() == 0)
                note_failure("result with nothing expected", '0, result);
            else
            begin
                want = expected_results.pop_front();
                if (result_differs(want, result))
                    note_failure("result mismatch", want, result);
            end
        end
    end

    // Result side: pop stays high except during random stalls.
    always @(negedge clk)
    begin
        if (pop_hold != 0)
        begin
            pop <= 1'b0;
            pop_hold <= pop_hold - 1;
        end
        else
        begin
            pop <= 1'b1;
            if (sink_idle_en && $urandom_range(0, 3) == 0)
                pop_hold <= gap_len();
        end
    end

    // Drives one transaction and waits until the block takes it. Push is left
    // high so that back-to-back items follow without a gap.
    task automatic send(input kind_t k, input logic [2:0] src, input logic [4:0] val,
                        input logic [15:0] pc, input logic [15:0] sp);
        in_item_t it;
        int       gap;
        it.kind = k;
        it.source = src;
        it.value = val;
        it.pc = pc;
        it.sp = sp;
        gap = src_idle_en ? gap_len() : 0;
        repeat (gap)
        begin
            @(negedge clk);
            push <= 1'b0;
        end
        @(negedge clk);
        push <= 1'b1;
        item <= it;
        do
            @(posedge clk);
        while (full);
        predict_dispatch(it);
        items_sent++;
    endtask

    task automatic test_reset_state();
        send(KIND_SERVICE, 3'd0, 5'd0, 16'h1234, 16'hC000);
    endtask

    task automatic test_request_flags();
        // Sources five to seven do not exist and must leave the flags alone.
        for (int s = 0; s < 8; s++)
            send(KIND_REQUEST, 3'(s), 5'h1F, 16'($urandom), 16'($urandom));
    endtask

    task automatic test_master_gating();
        send(KIND_ENABLE, 3'd7, 5'h1F, 16'hFFFF, 16'hFFFF);
        // Only bit 0 of the value counts for master enable.
        send(KIND_MASTER, 3'd0, 5'h1E, 16'h0000, 16'h0000);
        send(KIND_SERVICE, 3'd0, 5'h1F, 16'hABCD, 16'h8000);
    endtask

    task automatic test_priority_order();
        send(KIND_MASTER, 3'd0, 5'h01, 16'h0000, 16'h0000);
        send(KIND_SERVICE, 3'd0, 5'h00, 16'hFFFF, 16'h0000);
        send(KIND_SERVICE, 3'd0, 5'h00, 16'h4321, 16'hDFF0);
        send(KIND_MASTER, 3'd0, 5'h1F, 16'h0000, 16'h0000);
        send(KIND_SERVICE, 3'd0, 5'h00, 16'h0000, 16'h0001);
    endtask

    task automatic test_enable_mask();
        send(KIND_ENABLE, 3'd0, 5'h00, 16'h0000, 16'h0000);
        send(KIND_MASTER, 3'd0, 5'h01, 16'h0000, 16'h0000);
        send(KIND_SERVICE, 3'd0, 5'h00, 16'h1000, 16'h2000);
        send(KIND_ENABLE, 3'd0, 5'h10, 16'h0000, 16'h0000);
        send(KIND_SERVICE, 3'd0, 5'h00, 16'h8001, 16'hFFFF);
        send(KIND_ENABLE, 3'd0, 5'h0C, 16'h0000, 16'h0000);
        send(KIND_MASTER, 3'd0, 5'h01, 16'h0000, 16'h0000);
        send(KIND_SERVICE, 3'd0, 5'h00, 16'h7F80, 16'h0002);
    endtask

    // Mostly request / enable / master / check sequences with random content,
    // mixed with fully random transactions.
    task automatic test_random_traffic(input int n_items);
        int start;
        start = items_sent;
        while (items_sent - start < n_items)
        begin
            src_idle_en = ($urandom_range(0, 4) != 0);
            sink_idle_en = ($urandom_range(0, 4) != 0);
            if ($urandom_range(0, 9) < 7)
            begin
                repeat ($urandom_range(1, 3))
                    send(KIND_REQUEST,
                         ($urandom_range(0, 7) == 0) ? 3'($urandom_range(5, 7))
                                                     : 3'($urandom_range(0, 4)),
                         5'($urandom), 16'($urandom), 16'($urandom));
                if ($urandom_range(0, 2) == 0)
                    send(KIND_ENABLE, 3'($urandom),
                         ($urandom_range(0, 2) == 0) ? 5'($urandom) : 5'h1F,
                         16'($urandom), 16'($urandom));
                send(KIND_MASTER, 3'($urandom), 5'($urandom) | 5'h01,
                     16'($urandom), 16'($urandom));
                repeat ($urandom_range(1, 2))
                    send(KIND_SERVICE, 3'($urandom), 5'($urandom), 16'($urandom),
                         ($urandom_range(0, 7) == 0) ? 16'($urandom_range(0, 2))
                                                     : 16'($urandom));
            end
            else
                send(kind_t'($urandom_range(0, 3)), 3'($urandom), 5'($urandom),
                     16'($urandom), 16'($urandom));
        end
    endtask

    task automatic wait_drain();
        int guard;
        guard = 0;
        while (expected_results.size() != 0 && guard < 20000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (50) @(posedge clk);
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_reset_state();
        test_request_flags();
        test_master_gating();
        test_priority_order();
        test_enable_mask();
        test_random_traffic(155);

        @(negedge clk);
        push <= 1'b0;
        sink_idle_en = 1'b0;
        wait_drain();

        if (expected_results.size() != 0)
        begin
            fail_count++;
            $display("%0d expected results never arrived", expected_results.size());
        end
        $display("Sent %0d transactions and checked %0d results,", items_sent, results_seen);
        $display("with %0d interrupts dispatched under random stalls on both sides.",
                 dispatch_count);
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+rtl/core
rtl/core/ipd_pkg.sv
rtl/core/ipd_front.sv
rtl/core/ipd_job_queue.sv
rtl/core/ipd_back.sv
rtl/core/interrupt_priority_dispatch.sv
dv/tb_interrupt_priority_dispatch.sv
